### src/deq_pkg.sv
// Package for the double-ended queue: operation codes, status codes, fixed field widths and sequencer states.
// Has no dependencies; deq_rem and the top level refer to it by scoped names.
package deq_pkg;

  // Fixed widths of the transaction fields.
  localparam int KIND_W   = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 16;
  localparam int STATUS_W = 2;

  // Operation codes carried by the kind field.
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Sequencer states of the top level, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_OUT    = 5'b10000
  } deq_state_t;

endpackage

### src/deq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/deq_rem.sv
// Iterative remainder unit: position modulo element count, one quotient bit per cycle.
// Depends on deq_pkg for the position width.
module deq_rem #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [deq_pkg::POS_W-1:0]  dividend,
  input  logic [CW-1:0]              divisor,
  output logic                       done,
  output logic [AW-1:0]              remainder
);

  localparam int BW = $clog2(deq_pkg::POS_W);

  logic                      busy;
  logic [BW-1:0]             bit_idx;
  logic [deq_pkg::POS_W-1:0] num;
  logic [CW-1:0]             den;
  logic [CW-1:0]             rem;
  logic [CW:0]               shifted;
  logic [CW:0]               diff;
  logic [CW-1:0]             rem_next;

  // One restoring step: bring down the next bit and subtract when it fits.
  always_comb begin
    shifted = {rem, num[bit_idx]};
    diff    = shifted - {1'b0, den};
    if (shifted >= {1'b0, den}) begin
      rem_next = diff[CW-1:0];
    end else begin
      rem_next = shifted[CW-1:0];
    end
  end

  // Step counter and control; the divisor is never zero when started.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_idx <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_idx <= BW'(deq_pkg::POS_W - 1);
      end else if (busy) begin
        bit_idx <= bit_idx - 1'b1;
        if (bit_idx == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= rem_next;
    end
  end

  // The remainder is below the count, so it always fits an index.
  assign remainder = rem[AW-1:0];

endmodule

### src/double_ended_queue.sv
// Top level of the double-ended queue: sequencer, ring pointers and result register.
// Depends on deq_pkg, deq_ram and deq_rem.
//
//   Channel | Ports                                        | Direction
//   --------+----------------------------------------------+----------
//   in      | in_valid, in_ready, kind, push_value, position | to block
//   out     | out_valid, out_ready, value, status, count,    | from block
//           | is_empty                                     |
//
// A push, a rejected operation or an unused kind goes from accept through execute to result.
// A pop adds one registered read of the ring RAM.
// A read at a position runs 16 steps of the remainder unit, then the RAM read.
// In is not ready from accept until the result transaction completes.
// Synchronous reset empties the queue; RAM contents are not cleared.
module double_ended_queue #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [deq_pkg::KIND_W-1:0]          kind,
  input  logic signed [deq_pkg::VAL_W-1:0]    push_value,
  input  logic [deq_pkg::POS_W-1:0]           position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [deq_pkg::VAL_W-1:0]    value,
  output logic [deq_pkg::STATUS_W-1:0]        status,
  output logic [CW-1:0]                       count,
  output logic                                is_empty
);

  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  deq_pkg::deq_state_t state;

  logic [AW-1:0]                 head;
  logic [CW-1:0]                 elem_count;
  logic [deq_pkg::KIND_W-1:0]    op_kind;
  logic [deq_pkg::VAL_W-1:0]     op_value;
  logic [deq_pkg::POS_W-1:0]     op_pos;
  logic [deq_pkg::VAL_W-1:0]     value_q;
  logic [deq_pkg::STATUS_W-1:0]  status_q;

  logic                  full;
  logic                  empty;
  logic [CW-1:0]         cnt_dec;
  logic [AW-1:0]         front_prev;
  logic [AW-1:0]         back_slot;
  logic [AW-1:0]         last_slot;
  logic [AW-1:0]         head_inc;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [deq_pkg::VAL_W-1:0] ram_rdata;
  logic                  rem_start;
  logic                  rem_done;
  logic [AW-1:0]         rem_val;
  logic [AW-1:0]         read_slot;

  // Ring index of head plus an offset, with a single wrap.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  // Occupancy flags and ring addresses of the current operation.
  always_comb begin
    full       = (elem_count == DEPTH_C);
    empty      = (elem_count == '0);
    cnt_dec    = elem_count - 1'b1;
    front_prev = slot_of(head, AW'(DEPTH - 1));
    back_slot  = slot_of(head, elem_count[AW-1:0]);
    last_slot  = slot_of(head, cnt_dec[AW-1:0]);
    head_inc   = slot_of(head, AW'(1));
    read_slot  = slot_of(head, rem_val);
  end

  // RAM write for accepted pushes, read address for pops and positional reads, and remainder start.
  always_comb begin
    ram_we    = (state == deq_pkg::ST_EXEC) && !full &&
                ((op_kind == deq_pkg::KIND_PUSH_FRONT) ||
                 (op_kind == deq_pkg::KIND_PUSH_BACK));
    ram_waddr = (op_kind == deq_pkg::KIND_PUSH_FRONT) ? front_prev : back_slot;
    if (state == deq_pkg::ST_DIV) begin
      ram_raddr = read_slot;
    end else if (op_kind == deq_pkg::KIND_POP_FRONT) begin
      ram_raddr = head;
    end else begin
      ram_raddr = last_slot;
    end
    rem_start = (state == deq_pkg::ST_EXEC) && !empty &&
                (op_kind == deq_pkg::KIND_READ);
  end

  deq_ram #(
    .WIDTH (deq_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (op_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  deq_rem #(
    .DEPTH (DEPTH)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (op_pos),
    .divisor   (elem_count),
    .done      (rem_done),
    .remainder (rem_val)
  );

  // Sequencer, ring pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= deq_pkg::ST_IDLE;
      head       <= '0;
      elem_count <= '0;
    end else begin
      case (state)
        deq_pkg::ST_IDLE: begin
          if (in_valid) begin
            state <= deq_pkg::ST_EXEC;
          end
        end
        deq_pkg::ST_EXEC: begin
          case (op_kind)
            deq_pkg::KIND_PUSH_FRONT: begin
              state <= deq_pkg::ST_OUT;
              if (!full) begin
                head       <= front_prev;
                elem_count <= elem_count + 1'b1;
              end
            end
            deq_pkg::KIND_PUSH_BACK: begin
              state <= deq_pkg::ST_OUT;
              if (!full) begin
                elem_count <= elem_count + 1'b1;
              end
            end
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
              state <= empty ? deq_pkg::ST_OUT : deq_pkg::ST_RDWAIT;
            end
            deq_pkg::KIND_READ: begin
              state <= empty ? deq_pkg::ST_OUT : deq_pkg::ST_DIV;
            end
            default: begin
              state <= deq_pkg::ST_OUT;
            end
          endcase
        end
        deq_pkg::ST_DIV: begin
          if (rem_done) begin
            state <= deq_pkg::ST_RDWAIT;
          end
        end
        deq_pkg::ST_RDWAIT: begin
          state <= deq_pkg::ST_OUT;
          if (op_kind == deq_pkg::KIND_POP_FRONT) begin
            head       <= head_inc;
            elem_count <= cnt_dec;
          end else if (op_kind == deq_pkg::KIND_POP_BACK) begin
            elem_count <= cnt_dec;
          end
        end
        deq_pkg::ST_OUT: begin
          if (out_ready) begin
            state <= deq_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= deq_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Operation capture and result register.
  always_ff @(posedge clk) begin
    if (state == deq_pkg::ST_IDLE && in_valid) begin
      op_kind  <= kind;
      op_value <= push_value;
      op_pos   <= position;
    end
    if (state == deq_pkg::ST_EXEC) begin
      value_q  <= '0;
      status_q <= deq_pkg::STATUS_OK;
      case (op_kind)
        deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
          if (full) begin
            status_q <= deq_pkg::STATUS_FULL;
          end
        end
        deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK, deq_pkg::KIND_READ: begin
          if (empty) begin
            status_q <= deq_pkg::STATUS_EMPTY;
          end
        end
        default: begin
          status_q <= deq_pkg::STATUS_OK;
        end
      endcase
    end else if (state == deq_pkg::ST_RDWAIT) begin
      value_q <= ram_rdata;
    end
  end

  // Output transaction ports.
  assign in_ready  = (state == deq_pkg::ST_IDLE);
  assign out_valid = (state == deq_pkg::ST_OUT);
  assign value     = value_q;
  assign status    = status_q;
  assign count     = elem_count;
  assign is_empty  = empty;

endmodule
